// ===== hdl/fdcp_pkg.sv =====
// ----------------------------------------------------------------------------
// Framed decimal command parser package
// Shared types and constants: marker register set, result bundle, APB map.
// ----------------------------------------------------------------------------
package fdcp_pkg;

	// APB address width: three 32-bit registers at byte offsets 0, 4 and 8.
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// Register indexes (paddr[3:2]).
	localparam logic [1:0] REG_START_MARKER  = 2'd0;
	localparam logic [1:0] REG_END_MARKER    = 2'd1;
	localparam logic [1:0] REG_CUSTOM_MARKER = 2'd2;

	// Reset values of the marker registers: '<', '>' and '*'.
	localparam logic [7:0] START_MARKER_RST  = 8'h3C;
	localparam logic [7:0] END_MARKER_RST    = 8'h3E;
	localparam logic [7:0] CUSTOM_MARKER_RST = 8'h2A;

	// Magnitude saturation point and the largest positive result.
	localparam logic [31:0] SAT_MAG = 32'h8000_0000;
	localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

	// Message kinds.
	localparam logic KIND_NUMERIC = 1'b0;
	localparam logic KIND_CUSTOM  = 1'b1;

	typedef struct packed {
		logic [7:0] start_marker;
		logic [7:0] end_marker;
		logic [7:0] custom_marker;
	} markers_t;

	typedef struct packed {
		logic               emit;
		logic               message_kind;
		logic signed [31:0] selected_value;
	} result_t;

endpackage

// ===== hdl/fdcp_if.sv =====
// ----------------------------------------------------------------------------
// Framed decimal command parser channels
// Valid/ready channels for received bytes and for parsed results.
// ----------------------------------------------------------------------------

// Received byte channel.
interface fdcp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// Parsed result channel.
interface fdcp_result_if;
	logic               valid;
	logic               ready;
	logic               message_kind;
	logic signed [31:0] selected_value;

	modport source (output valid, output message_kind, output selected_value, input ready);
	modport sink (input valid, input message_kind, input selected_value, output ready);
endinterface

// ===== hdl/framed_decimal_command_parser.sv =====
// ----------------------------------------------------------------------------
// Framed decimal command parser
// Takes one received byte per request on rx and returns one result on result
// for every frame closed by the end marker. Bytes outside a frame are ignored
// until the start marker; the first BUFFER_CHARS-1 payload bytes are read as a
// custom message (first byte equal to the custom marker) or as a signed decimal
// number in the manner of atoi, saturated to 32 bits. The block takes a new
// byte every clock cycle unless input stalls; a byte passes an input register
// and the frame and number logic (one multiply-by-ten-and-add), and its
// result, if any, is registered in the result register. Input stalls only
// while a result waits in the result register and a further byte is
// already held in the input register. The three marker registers sit on the
// APB port at byte offsets 0, 4 and 8 and should be written only while idle.
// ----------------------------------------------------------------------------
module framed_decimal_command_parser #(
	parameter int BUFFER_CHARS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fdcp_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [fdcp_pkg::APB_DATA_W-1:0] pwdata,
	output logic [fdcp_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	fdcp_byte_if.sink                       rx,
	fdcp_result_if.source                   result
);

	fdcp_pkg::markers_t markers;
	fdcp_pkg::result_t  res;

	logic               valid_s1;
	logic [7:0]         rx_byte_s1;
	logic               res_valid_s2;
	logic               res_kind_s2;
	logic signed [31:0] res_value_s2;
	logic               stall;
	logic               s1_fire;

	fdcp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.markers (markers)
	);

	fdcp_parse #(
		.BUFFER_CHARS (BUFFER_CHARS)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (s1_fire),
		.rx_byte (rx_byte_s1),
		.markers (markers),
		.res     (res)
	);

	// Flow control: the input stage moves on unless a result is still waiting.
	assign stall    = res_valid_s2 && !result.ready;
	assign s1_fire  = valid_s1 && !stall;
	assign rx.ready = !valid_s1 || !stall;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (s1_fire) begin
			res_valid_s2 <= res.emit;
		end else if (result.ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && res.emit) begin
			res_kind_s2  <= res.message_kind;
			res_value_s2 <= res.selected_value;
		end
	end

	assign result.valid          = res_valid_s2;
	assign result.message_kind   = res_kind_s2;
	assign result.selected_value = res_value_s2;

`ifndef ASSERT_OFF
	// A new result only ever follows a byte leaving the input stage.
	a_result_from_byte: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_s2) |-> $past(s1_fire))
		else $error("result appeared without a byte being processed");

	// A newly accepted byte never overwrites one that has not been processed.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rx.valid && rx.ready) |-> (!valid_s1 || s1_fire))
		else $error("input stage overwritten while still holding a byte");

	// A custom message always carries a zero value.
	a_custom_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.message_kind == fdcp_pkg::KIND_CUSTOM))
		|-> (result.selected_value == 32'sd0))
		else $error("custom message with non-zero value");
`endif

endmodule

// ===== hdl/fdcp_cfg.sv =====
// ----------------------------------------------------------------------------
// Framed decimal command parser register file
// APB slave holding the start, end and custom marker bytes.
// ----------------------------------------------------------------------------
module fdcp_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fdcp_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [fdcp_pkg::APB_DATA_W-1:0] pwdata,
	output logic [fdcp_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	output fdcp_pkg::markers_t              markers
);

	logic       wr_en;
	logic [1:0] reg_idx;
	logic [7:0] start_marker_q;
	logic [7:0] end_marker_q;
	logic [7:0] custom_marker_q;

	// The write completes in the access phase; there are no wait states.
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[fdcp_pkg::APB_ADDR_W-1:2];

	// Marker registers; writes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q  <= fdcp_pkg::START_MARKER_RST;
			end_marker_q    <= fdcp_pkg::END_MARKER_RST;
			custom_marker_q <= fdcp_pkg::CUSTOM_MARKER_RST;
		end else if (wr_en) begin
			case (reg_idx)
				fdcp_pkg::REG_START_MARKER:  start_marker_q  <= pwdata[7:0];
				fdcp_pkg::REG_END_MARKER:    end_marker_q    <= pwdata[7:0];
				fdcp_pkg::REG_CUSTOM_MARKER: custom_marker_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read mux; unmapped addresses read as zero.
	always_comb begin
		case (reg_idx)
			fdcp_pkg::REG_START_MARKER:  prdata = {24'd0, start_marker_q};
			fdcp_pkg::REG_END_MARKER:    prdata = {24'd0, end_marker_q};
			fdcp_pkg::REG_CUSTOM_MARKER: prdata = {24'd0, custom_marker_q};
			default:                     prdata = '0;
		endcase
	end

	assign markers.start_marker  = start_marker_q;
	assign markers.end_marker    = end_marker_q;
	assign markers.custom_marker = custom_marker_q;

endmodule

// ===== hdl/fdcp_parse.sv =====
// ----------------------------------------------------------------------------
// Framed decimal command parser frame and number state
// Tracks framing; accumulates the decimal value one byte per cycle on fire.
// ----------------------------------------------------------------------------
module fdcp_parse #(
	parameter int BUFFER_CHARS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic [7:0]         rx_byte,
	input  fdcp_pkg::markers_t markers,
	output fdcp_pkg::result_t  res
);

	localparam int              CNT_W     = $clog2(BUFFER_CHARS);
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BUFFER_CHARS - 1);

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [1:0] {
		PH_SPACE,
		PH_SIGN,
		PH_DIGITS,
		PH_STOP
	} phase_t;

	logic             in_frame_q, in_frame_n;
	logic [CNT_W-1:0] count_q, count_n;
	phase_t           phase_q, phase_n;
	logic             neg_q, neg_n;
	logic             custom_q, custom_n;
	logic [31:0]      mag_q, mag_n;

	logic             is_digit;
	logic             is_space;
	logic [3:0]       digit_val;
	logic [35:0]      mag_wide;
	logic [35:0]      mag_x10;
	logic [31:0]      mag_acc;
	logic             custom_res;
	logic [31:0]      value_res;

	// Byte classification and the saturating multiply-by-ten-and-add.
	always_comb begin
		is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
		is_space  = rx_byte inside {[CH_TAB:CH_CR], CH_SPACE};
		digit_val = 4'(rx_byte - CH_ZERO);
		mag_wide  = 36'(mag_q);
		mag_x10   = (mag_wide << 3) + (mag_wide << 1) + 36'(digit_val);
		mag_acc   = (mag_x10 > 36'(fdcp_pkg::SAT_MAG)) ? fdcp_pkg::SAT_MAG : mag_x10[31:0];
	end

	// Result of a closing end marker, formed from the state before it.
	always_comb begin
		custom_res = custom_q || ((count_q == '0) && (markers.custom_marker == 8'd0));
		if (neg_q) begin
			value_res = 32'd0 - mag_q;
		end else if (mag_q[31]) begin
			value_res = fdcp_pkg::INT_MAX;
		end else begin
			value_res = mag_q;
		end
	end

	// Next state of the frame and parser for the byte in the input stage.
	always_comb begin
		in_frame_n         = in_frame_q;
		count_n            = count_q;
		phase_n            = phase_q;
		neg_n              = neg_q;
		custom_n           = custom_q;
		mag_n              = mag_q;
		res.emit           = 1'b0;
		res.message_kind   = custom_res;
		res.selected_value = custom_res ? 32'sd0 : $signed(value_res);

		if (!in_frame_q) begin
			// Outside a frame only the start marker matters.
			if (rx_byte == markers.start_marker) begin
				in_frame_n = 1'b1;
				count_n    = '0;
				phase_n    = PH_SPACE;
				neg_n      = 1'b0;
				custom_n   = 1'b0;
				mag_n      = '0;
			end
		end else if (rx_byte != markers.end_marker) begin
			// Payload byte, dropped once the buffer is full.
			if (count_q < CNT_LIMIT) begin
				count_n = count_q + 1'b1;
				if ((count_q == '0) && (rx_byte == markers.custom_marker)) begin
					custom_n = 1'b1;
				end
				case (phase_q)
					PH_SPACE: begin
						if (is_space) begin
							phase_n = PH_SPACE;
						end else if ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS)) begin
							neg_n   = (rx_byte == CH_MINUS);
							phase_n = PH_SIGN;
						end else if (is_digit) begin
							mag_n   = 32'(digit_val);
							phase_n = PH_DIGITS;
						end else begin
							phase_n = PH_STOP;
						end
					end
					PH_SIGN, PH_DIGITS: begin
						if (is_digit) begin
							mag_n   = mag_acc;
							phase_n = PH_DIGITS;
						end else begin
							phase_n = PH_STOP;
						end
					end
					default: ;
				endcase
			end
		end else begin
			// End marker closes the frame and releases one result.
			res.emit   = 1'b1;
			in_frame_n = 1'b0;
			count_n    = '0;
			phase_n    = PH_SPACE;
			neg_n      = 1'b0;
			custom_n   = 1'b0;
			mag_n      = '0;
		end
	end

	// Frame and parser state, advanced once per byte taken from the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
			phase_q    <= PH_SPACE;
			neg_q      <= 1'b0;
			custom_q   <= 1'b0;
			mag_q      <= '0;
		end else if (fire) begin
			in_frame_q <= in_frame_n;
			count_q    <= count_n;
			phase_q    <= phase_n;
			neg_q      <= neg_n;
			custom_q   <= custom_n;
			mag_q      <= mag_n;
		end
	end

endmodule

// ===== dv/framed_decimal_command_parser_tb.sv =====
// ----------------------------------------------------------------------------
// Framed decimal command parser testbench
// Sends framed byte streams through the rx channel and checks every parsed
// command on the result channel against a cycle-free model of the framing and
// atoi-style number reading. The marker registers are reprogrammed over APB
// between phases, and both channels idle at random, with one long result
// hold-off that backs the parser up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module framed_decimal_command_parser_tb;

	localparam int          BUFFER_CHARS = 32;
	localparam int          DRAIN_CYCLES = 8;
	localparam int          LONG_HOLD    = 400;
	localparam int unsigned PHASE_BYTES  = 280;

	// Character classes used by the number reader.
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Progress of the number reader within one frame.
	typedef enum logic [1:0] {
		SCAN_SPACE   = 2'd0,
		SCAN_SIGN    = 2'd1,
		SCAN_DIGITS  = 2'd2,
		SCAN_STOPPED = 2'd3
	} scan_t;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] value;
	} command_t;

	// Tracks the frame state, predicts parsed commands and checks the results.
	class command_scoreboard;
		fdcp_pkg::markers_t markers;
		bit                 in_frame;
		int unsigned        payload_len;
		scan_t              scan;
		bit                 negative;
		bit                 custom;
		logic [31:0]        magnitude;
		command_t           expected_q[$];
		int                 errors;

		function new();
			markers   = '{fdcp_pkg::START_MARKER_RST, fdcp_pkg::END_MARKER_RST,
				fdcp_pkg::CUSTOM_MARKER_RST};
			in_frame  = 1'b0;
			errors    = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			payload_len = 0;
			scan        = SCAN_SPACE;
			negative    = 1'b0;
			custom      = 1'b0;
			magnitude   = '0;
		endfunction

		function void set_marker(logic [1:0] index, logic [7:0] value);
			case (index)
				fdcp_pkg::REG_START_MARKER:  markers.start_marker  = value;
				fdcp_pkg::REG_END_MARKER:    markers.end_marker    = value;
				fdcp_pkg::REG_CUSTOM_MARKER: markers.custom_marker = value;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Note one accepted byte; a closing end marker queues one command.
		function void take_byte(logic [7:0] c);
			logic [35:0] grown;
			bit          digit;
			bit          blank;
			command_t    cmd;

			if (!in_frame) begin
				if (c == markers.start_marker) begin
					in_frame = 1'b1;
					clear_frame();
				end
				return;
			end

			// Payload byte: only the first BUFFER_CHARS-1 take part.
			if (c != markers.end_marker) begin
				if (payload_len < BUFFER_CHARS - 1) begin
					digit = (c >= CH_ZERO) && (c <= CH_NINE);
					blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
					if (payload_len == 0 && c == markers.custom_marker)
						custom = 1'b1;
					case (scan)
						SCAN_SPACE: begin
							if (!blank) begin
								if (c == CH_PLUS || c == CH_MINUS) begin
									negative = (c == CH_MINUS);
									scan     = SCAN_SIGN;
								end else if (digit) begin
									magnitude = {24'd0, c - CH_ZERO};
									scan      = SCAN_DIGITS;
								end else begin
									scan = SCAN_STOPPED;
								end
							end
						end
						SCAN_SIGN, SCAN_DIGITS: begin
							if (digit) begin
								grown = {4'd0, magnitude} * 36'd10 + {28'd0, c - CH_ZERO};
								magnitude = (grown > {4'd0, fdcp_pkg::SAT_MAG}) ?
									fdcp_pkg::SAT_MAG : grown[31:0];
								scan = SCAN_DIGITS;
							end else begin
								scan = SCAN_STOPPED;
							end
						end
						default: ;
					endcase
					payload_len++;
				end
				return;
			end

			// End marker: an empty frame reads a zero byte as its first byte.
			if (custom || (payload_len == 0 && markers.custom_marker == 8'd0)) begin
				cmd.kind  = fdcp_pkg::KIND_CUSTOM;
				cmd.value = '0;
			end else begin
				cmd.kind = fdcp_pkg::KIND_NUMERIC;
				if (negative)
					cmd.value = 32'd0 - magnitude;
				else
					cmd.value = (magnitude > fdcp_pkg::INT_MAX) ?
						fdcp_pkg::INT_MAX : magnitude;
			end
			expected_q.push_back(cmd);
			in_frame = 1'b0;
			clear_frame();
		endfunction

		// Compare one returned command with the oldest prediction.
		function void check_command(logic kind, logic signed [31:0] value);
			command_t exp_cmd;

			if (expected_q.size() == 0) begin
				$error("unexpected result: message_kind %0d, selected_value %0d", kind, value);
				errors++;
				return;
			end
			exp_cmd = expected_q.pop_front();
			if (kind !== exp_cmd.kind) begin
				$error("message_kind: expected %0d, actual %0d", exp_cmd.kind, kind);
				errors++;
			end
			if (value !== exp_cmd.value) begin
				$error("selected_value: expected %0d, actual %0d", exp_cmd.value, value);
				errors++;
			end
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [fdcp_pkg::APB_ADDR_W-1:0] paddr;
	logic [fdcp_pkg::APB_DATA_W-1:0] pwdata;
	logic [fdcp_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;

	fdcp_byte_if   rx ();
	fdcp_result_if result ();

	command_scoreboard sb = new();

	int unsigned send_idle;
	int unsigned recv_idle;
	int unsigned bytes_sent;
	bit          pressure_go;
	bit          hold_off;

	framed_decimal_command_parser #(
		.BUFFER_CHARS(BUFFER_CHARS)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.rx     (rx.sink),
		.result (result.source)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off when asked for.
	initial begin : result_receiver
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			result.ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle);
		end
	end

	initial begin : long_hold
		hold_off = 1'b0;
		wait (pressure_go);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		hold_off = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready)
			sb.check_command(result.message_kind, result.selected_value);
	end

	function automatic logic [7:0] pick_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] pick_space();
		return ($urandom_range(0, 5) == 0) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4));
	endfunction

	// Markers that do not collide with digits, signs or whitespace.
	function automatic logic [7:0] pick_marker();
		logic [7:0] v;
		do
			v = 8'($urandom_range(0, 255));
		while ((v >= CH_ZERO && v <= CH_NINE) || v == CH_PLUS || v == CH_MINUS ||
		       v == CH_SPACE || (v >= CH_TAB && v <= CH_CR));
		return v;
	endfunction

	// Offer one byte from a falling edge and hold it until the request is taken.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle) begin
			rx.valid <= 1'b0;
			@(negedge clk);
		end
		rx.valid   <= 1'b1;
		rx.rx_byte <= b;
		do @(posedge clk); while (!rx.ready);
		sb.take_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Write a marker register, then read it back unless the index is unused.
	task automatic program_marker(input logic [1:0] index, input logic [7:0] value);
		logic [7:0] readback;

		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= ($urandom() & 32'hFFFF_FF00) | {24'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_marker(index, value);
		@(negedge clk);
		if (index != fdcp_pkg::REG_START_MARKER && index != fdcp_pkg::REG_END_MARKER &&
		    index != fdcp_pkg::REG_CUSTOM_MARKER) begin
			psel    <= 1'b0;
			penable <= 1'b0;
			pwrite  <= 1'b0;
			return;
		end
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata[7:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (readback !== value) begin
			$error("marker register %0d: expected %0d, actual %0d", index, value, readback);
			sb.errors++;
		end
	endtask

	// One frame with random content, sometimes preceded by stray bytes.
	task automatic send_random_frame();
		int unsigned n;

		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom()));
		send_byte(sb.markers.start_marker);
		case ($urandom_range(0, 9))
			0: n = 0;
			1: begin
				send_byte(sb.markers.custom_marker);
				repeat ($urandom_range(0, 5)) send_byte(8'($urandom()));
			end
			2: begin
				// Long payload: digits may fall past the counted part.
				repeat ($urandom_range(BUFFER_CHARS - 12, BUFFER_CHARS + 2))
					send_byte(pick_space());
				repeat ($urandom_range(1, 8)) send_byte(pick_digit());
			end
			3: repeat ($urandom_range(1, 5)) send_byte(8'($urandom()));
			default: begin
				repeat ($urandom_range(0, 2)) send_byte(pick_space());
				case ($urandom_range(0, 2))
					0: send_byte(CH_PLUS);
					1: send_byte(CH_MINUS);
					default: ;
				endcase
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 6);
				repeat (n) send_byte(pick_digit());
				if ($urandom_range(0, 3) == 0)
					send_byte(8'($urandom()));
			end
		endcase
		send_byte(sb.markers.end_marker);
	endtask

	// Stop sending and wait until every command has come back.
	task automatic settle();
		rx.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input int unsigned n_bytes);
		int unsigned target;

		target = bytes_sent + n_bytes;
		while (bytes_sent < target)
			send_random_frame();
		settle();
	endtask

	task automatic set_idling(input int unsigned sender, input int unsigned receiver);
		@(posedge clk);
		send_idle = sender;
		recv_idle = receiver;
		@(negedge clk);
	endtask

	initial begin : stimulus
		logic [7:0] shared;

		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		rx.valid    = 1'b0;
		rx.rx_byte  = '0;
		send_idle   = 34;
		recv_idle   = 45;
		bytes_sent  = 0;
		pressure_go = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames with the reset markers: empty, custom, whitespace
		// and sign with a trailing stop, overflow, and a zero byte in digits.
		send_byte(8'hFF);
		send_text("<>");
		send_text("<*>");
		send_text("<\t-42x>");
		send_text("<9999999999>");
		send_byte(fdcp_pkg::START_MARKER_RST);
		send_byte(8'h33);
		send_byte(8'h00);
		send_byte(8'h34);
		send_byte(fdcp_pkg::END_MARKER_RST);
		run_phase(PHASE_BYTES);

		// Lowest start and custom markers, highest end marker.
		program_marker(fdcp_pkg::REG_START_MARKER, 8'h00);
		program_marker(fdcp_pkg::REG_END_MARKER, 8'hFF);
		program_marker(fdcp_pkg::REG_CUSTOM_MARKER, 8'h00);
		run_phase(PHASE_BYTES);

		set_idling(45, 34);
		program_marker(fdcp_pkg::REG_START_MARKER, 8'hFF);
		program_marker(fdcp_pkg::REG_END_MARKER, 8'h00);
		program_marker(fdcp_pkg::REG_CUSTOM_MARKER, 8'hFF);
		run_phase(PHASE_BYTES);

		// Equal start and end markers: the closing byte cannot reopen.
		shared = pick_marker();
		program_marker(fdcp_pkg::REG_START_MARKER, shared);
		program_marker(fdcp_pkg::REG_END_MARKER, shared);
		program_marker(fdcp_pkg::REG_CUSTOM_MARKER, pick_marker());
		run_phase(PHASE_BYTES);

		// No idling; the long result hold-off backs the parser up.
		set_idling(0, 0);
		program_marker(fdcp_pkg::REG_START_MARKER, pick_marker());
		program_marker(fdcp_pkg::REG_END_MARKER, pick_marker());
		program_marker(fdcp_pkg::REG_CUSTOM_MARKER, pick_marker());
		pressure_go = 1'b1;
		run_phase(PHASE_BYTES);

		// An unused register index must leave the markers alone.
		program_marker(2'd3, pick_marker());
		program_marker(fdcp_pkg::REG_START_MARKER, fdcp_pkg::START_MARKER_RST);
		program_marker(fdcp_pkg::REG_END_MARKER, fdcp_pkg::END_MARKER_RST);
		program_marker(fdcp_pkg::REG_CUSTOM_MARKER, fdcp_pkg::CUSTOM_MARKER_RST);
		run_phase(PHASE_BYTES);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/fdcp_pkg.sv
hdl/fdcp_if.sv
hdl/fdcp_cfg.sv
hdl/fdcp_parse.sv
hdl/framed_decimal_command_parser.sv
dv/framed_decimal_command_parser_tb.sv
